### hdl/uida_pkg.sv
// Shared constants, codes and types for the unique ID allocator.
// No dependencies; imported by every module of the block.
package uida_pkg;

    localparam int MAX_IDS     = 1024;
    localparam int TABLE_SLOTS = 32;
    localparam int ID_W        = 10;
    localparam int CNT_W       = $clog2(MAX_IDS + 1);
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int LIVE_W      = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_LOOKUP  = 2'd2,
        REQ_SPARE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        t_status           status;
        logic [SLOT_W-1:0] slot;
    } t_result;

endpackage

### hdl/uida_id_ram.sv
// ID table storage: one write port, one read port, registered read data.
// Depends on uida_pkg.
module uida_id_ram
    import uida_pkg::*;
(
    input  logic            i_clk,
    input  t_ram_req        i_req,
    output logic [ID_W-1:0] o_rdata
);

    logic [ID_W-1:0] r_mem [TABLE_SLOTS];
    logic [ID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/uida_ctrl.sv
// Request sequencer: table scans over the ID RAM, counter and bound update, slot fill.
// Depends on uida_pkg; drives uida_id_ram through a t_ram_req struct.
module uida_ctrl
    import uida_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    input  logic [ID_W-1:0]   i_id_in,
    output logic              o_in_ready,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_ready,
    output t_ram_req          o_ram,
    input  logic [ID_W-1:0]   i_rdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0]  LastMax  = CNT_W'(MAX_IDS);
    localparam logic [CNT_W-1:0]  LastOne  = CNT_W'(1);
    localparam logic [SLOT_W:0]   ScanEnd  = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(TABLE_SLOTS - 1);

    t_state                 r_state, n_state;
    logic [1:0]             r_req, n_req;
    logic [ID_W-1:0]        r_id, n_id;
    logic                   r_alloc, n_alloc;
    logic [CNT_W-1:0]       r_last, n_last;
    logic [CNT_W-1:0]       r_bound, n_bound;
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;
    logic [LIVE_W-1:0]      r_live, n_live;
    logic [SLOT_W:0]        r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                   r_dv, n_dv;
    t_result                r_res, n_res;

    logic [CNT_W-1:0]  last_inc;
    logic [CNT_W-1:0]  data_ext;
    logic              slot_live;
    logic              table_full;
    logic [SLOT_W-1:0] free_slot;

    // lowest slot whose valid bit is clear
    function automatic logic [SLOT_W-1:0] first_free(input logic [TABLE_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    assign last_inc   = r_last + LastOne;
    assign data_ext   = CNT_W'(i_rdata);
    assign slot_live  = r_valid[r_cmp_idx];
    assign free_slot  = first_free(r_valid);
    assign table_full = (32'(r_live) >= TABLE_SLOTS) || (32'(r_live) >= MAX_IDS - 1);

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_id      = r_id;
        n_alloc   = r_alloc;
        n_last    = r_last;
        n_bound   = r_bound;
        n_valid   = r_valid;
        n_live    = r_live;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_dv      = r_dv;
        n_res     = r_res;

        o_ram.we    = 1'b0;
        o_ram.waddr = free_slot;
        o_ram.wdata = r_last[ID_W-1:0];
        o_ram.raddr = r_rd_idx[SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                n_rd_idx = '0;
                n_dv     = 1'b0;
                if (i_in_valid) begin
                    n_req = i_req_type;
                    n_id  = i_id_in;
                    if (t_req'(i_req_type) == REQ_ALLOC) begin
                        n_alloc = 1'b1;
                        if (table_full) begin
                            n_res   = '{id: '0, status: ST_FULL, slot: '0};
                            n_state = S_RESULT;
                        end else if (last_inc >= LastMax) begin
                            n_last  = LastOne;
                            n_bound = LastMax;
                            n_state = S_SCAN;
                        end else if (last_inc >= r_bound) begin
                            n_last  = last_inc;
                            n_bound = LastMax;
                            n_state = S_SCAN;
                        end else begin
                            n_last  = last_inc;
                            n_state = S_WRITE;
                        end
                    end else begin
                        n_alloc = 1'b0;
                        if (i_id_in == '0 || 32'(i_id_in) >= MAX_IDS) begin
                            n_res   = '{id: i_id_in, status: ST_RANGE, slot: '0};
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // one read issued per cycle, compared the cycle after
                n_dv      = (r_rd_idx < ScanEnd);
                n_cmp_idx = r_rd_idx[SLOT_W-1:0];
                if (r_rd_idx < ScanEnd) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_dv) begin
                    if (!r_alloc) begin
                        if (slot_live && i_rdata == r_id) begin
                            n_res   = '{id: r_id, status: ST_OK, slot: r_cmp_idx};
                            n_state = S_RESULT;
                            if (t_req'(r_req) == REQ_RELEASE) begin
                                n_valid[r_cmp_idx] = 1'b0;
                                if (r_live != '0) begin
                                    n_live = r_live - 1'b1;
                                end
                            end
                        end else if (r_cmp_idx == SlotLast) begin
                            n_res   = '{id: r_id, status: ST_NOT_FOUND, slot: '0};
                            n_state = S_RESULT;
                        end
                    end else if (slot_live && data_ext == r_last) begin
                        if (last_inc >= r_bound) begin
                            // collision at the bound: restart the sweep from slot zero
                            n_last   = (last_inc >= LastMax) ? LastOne : last_inc;
                            n_bound  = LastMax;
                            n_rd_idx = '0;
                            n_dv     = 1'b0;
                        end else begin
                            n_last = last_inc;
                            if (r_cmp_idx == SlotLast) begin
                                n_state = S_WRITE;
                            end
                        end
                    end else begin
                        if (slot_live && data_ext > r_last && r_bound > data_ext) begin
                            n_bound = data_ext;
                        end
                        if (r_cmp_idx == SlotLast) begin
                            n_state = S_WRITE;
                        end
                    end
                end
            end

            S_WRITE: begin
                // a free slot exists: live count is below the slot count here
                o_ram.we           = 1'b1;
                n_valid[free_slot] = 1'b1;
                n_live             = r_live + 1'b1;
                n_res              = '{id: r_last[ID_W-1:0], status: ST_OK, slot: free_slot};
                n_state            = S_RESULT;
            end

            S_RESULT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= LastMax;
            r_bound <= LastMax;
            r_valid <= '0;
            r_live  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_bound <= n_bound;
            r_valid <= n_valid;
            r_live  <= n_live;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_id      <= n_id;
        r_alloc   <= n_alloc;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_res     <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

endmodule

### hdl/unique_id_allocator.sv
// Unique ID allocator. An allocate with no rescan goes straight to the slot write; an
// allocate with rescan sweeps all 32 slots (a collision at the bound restarts the sweep);
// release and lookup do one RAM read per slot and a hit ends early; full or bad ID: no scan.
// Throughput: one item in flight; the next is taken while a result waits in the output reg.
// Reset: synchronous active low; valid bits and live count cleared, counter and bound set
// to MAX_IDS at once; ID RAM contents are not cleared and no clearing pass runs.
module unique_id_allocator
    import uida_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [ID_W-1:0]   i_id_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ID_W-1:0]   o_id_out,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_slot
);

    t_ram_req        ram_req;
    logic [ID_W-1:0] ram_rdata;
    logic            res_valid;
    logic            res_ready;
    t_result         res;

    logic    r_out_valid;
    t_result r_out;

    uida_id_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    uida_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_id_in     (i_id_in),
        .o_in_ready  (o_in_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_id_out    = r_out.id;
    assign o_status    = r_out.status;
    assign o_slot      = r_out.slot;

endmodule

### sim/unique_id_allocator_tb.sv
// Self-checking testbench for unique_id_allocator: directed and random allocate,
// release and lookup items, checked against an in-bench model of the ID table.
// Depends on hdl/uida_pkg.sv and hdl/unique_id_allocator.sv.
module unique_id_allocator_tb;
    import uida_pkg::*;

    localparam int STALL_LIMIT = 8000;
    localparam int RAND_ITEMS  = 1200;

    typedef enum {MIX_FILL, MIX_CHURN, MIX_NOISE} t_mix;

    typedef struct {
        t_req            req;
        logic [ID_W-1:0] id;
    } t_id_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_req_type = REQ_LOOKUP;
    logic [ID_W-1:0]   i_id_in = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [ID_W-1:0]   o_id_out;
    logic [1:0]        o_status;
    logic [SLOT_W-1:0] o_slot;

    unique_id_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_id_in     (i_id_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_id_out    (o_id_out),
        .o_status    (o_status),
        .o_slot      (o_slot)
    );

    // shadow of the ID table and allocation counter
    logic [ID_W-1:0] tab_id [TABLE_SLOTS];
    logic            tab_live [TABLE_SLOTS];
    int              live_n = 0;
    int              ctr = MAX_IDS;
    int              bound = MAX_IDS;
    int              n_wraps = 0;

    t_id_req pend_q [$];
    t_result resp_q [$];
    int      n_pushed = 0;
    int      n_acc = 0;
    int      n_err = 0;
    int      n_res = 0;
    int      st_cnt [4] = '{0, 0, 0, 0};
    int      idle_cyc = 0;
    int      in_gap = 0;
    int      out_wait = 0;
    bit      burst = 1'b0;
    logic    in_hs = 1'b0;
    logic    out_hs = 1'b0;

    initial begin
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            tab_live[k] = 1'b0;
            tab_id[k]   = '0;
        end
    end

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int draw_gap();
        if (burst)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Applies one item to the shadow table and returns the response it should produce.
    function automatic t_result alloc_predict(t_req req, logic [ID_W-1:0] id);
        t_result r;
        int      i;
        int      s;
        bit      rescan;
        r.id     = '0;
        r.status = ST_OK;
        r.slot   = '0;
        s        = -1;
        if (req == REQ_ALLOC) begin
            if (live_n >= TABLE_SLOTS || live_n >= MAX_IDS - 1) begin
                r.status = ST_FULL;
            end else begin
                ctr++;
                rescan = 1'b0;
                if (ctr >= MAX_IDS) begin
                    ctr = 1;
                    rescan = 1'b1;
                    n_wraps++;
                end else if (ctr >= bound) begin
                    rescan = 1'b1;
                end
                if (rescan) begin
                    bound = MAX_IDS;
                    i = 0;
                    while (i < TABLE_SLOTS) begin
                        if (tab_live[i] && int'(tab_id[i]) == ctr) begin
                            ctr++;
                            // collision ran into the bound: wrap if needed, sweep again
                            if (ctr >= bound) begin
                                if (ctr >= MAX_IDS) begin
                                    ctr = 1;
                                    n_wraps++;
                                end
                                bound = MAX_IDS;
                                i = -1;
                            end
                        end else if (tab_live[i] && int'(tab_id[i]) > ctr &&
                                     bound > int'(tab_id[i])) begin
                            bound = int'(tab_id[i]);
                        end
                        i++;
                    end
                end
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (!tab_live[i]) begin
                        s = i;
                        break;
                    end
                end
                if (s >= 0) begin
                    tab_id[s]   = ID_W'(ctr);
                    tab_live[s] = 1'b1;
                    live_n++;
                    r.id   = ID_W'(ctr);
                    r.slot = SLOT_W'(s);
                end else begin
                    r.status = ST_FULL;
                end
            end
        end else begin
            r.id = id;
            if (id == 0 || int'(id) >= MAX_IDS) begin
                r.status = ST_RANGE;
            end else begin
                for (i = 0; i < TABLE_SLOTS; i++) begin
                    if (tab_live[i] && tab_id[i] == id) begin
                        s = i;
                        break;
                    end
                end
                if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.slot = SLOT_W'(s);
                    // the spare code behaves as a lookup
                    if (req == REQ_RELEASE) begin
                        tab_live[s] = 1'b0;
                        if (live_n > 0)
                            live_n--;
                    end
                end
            end
        end
        return r;
    endfunction

    // a random live ID, or any nonzero ID when the table is empty
    function automatic logic [ID_W-1:0] live_pick();
        int live_ids [$];
        for (int k = 0; k < TABLE_SLOTS; k++)
            if (tab_live[k])
                live_ids.push_back(int'(tab_id[k]));
        if (live_ids.size() == 0)
            return ID_W'($urandom_range(1, MAX_IDS - 1));
        return ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
    endfunction

    task automatic issue(t_req req, int id);
        t_id_req it;
        wait (n_acc == n_pushed);
        it.req = req;
        it.id  = ID_W'(id);
        pend_q.push_back(it);
        n_pushed++;
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_id_req it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && in_hs)
                in_gap = draw_gap();
            if (i_in_valid && !in_hs) begin
                // hold the item until it is taken
            end else if (in_gap != 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                it = pend_q.pop_front();
                i_in_valid <= 1'b1;
                i_req_type <= it.req;
                i_id_in    <= it.id;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready: after each result, hold ready low for a draw_gap() pause (none in burst mode)
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_hs)
                out_wait = draw_gap();
            if (out_wait != 0) begin
                out_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // accepted request: update the shadow table and queue the expected response
    always @(posedge i_clk) begin
        in_hs <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            resp_q.push_back(alloc_predict(t_req'(i_req_type), i_id_in));
            n_acc++;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_result e;
        out_hs <= o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_res++;
            st_cnt[o_status]++;
            if (resp_q.size() == 0) begin
                n_err++;
                if (n_err <= 20)
                    $display("%0t: unexpected response id %0d status %0d slot %0d",
                             $time, o_id_out, o_status, o_slot);
            end else begin
                e = resp_q.pop_front();
                if (o_id_out !== e.id || o_status !== e.status || o_slot !== e.slot) begin
                    n_err++;
                    if (n_err <= 20)
                        $display("%0t: mismatch expected id %0d status %0d slot %0d, %s %0d %0d %0d",
                                 $time, e.id, e.status, e.slot, "got",
                                 o_id_out, o_status, o_slot);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d responses outstanding",
                         $time, STALL_LIMIT, resp_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_mix mix;
        int   roll;
        mix = MIX_CHURN;

        // empty table, range and spare-code cases
        issue(REQ_LOOKUP, 5);
        issue(REQ_RELEASE, 0);
        issue(REQ_LOOKUP, 0);
        issue(REQ_SPARE, 0);
        issue(REQ_SPARE, 1023);
        // the first allocation wraps the counter and rescans an empty table
        issue(REQ_ALLOC, 1023);
        issue(REQ_ALLOC, 0);
        issue(REQ_ALLOC, 682);
        issue(REQ_LOOKUP, 2);
        issue(REQ_SPARE, 3);
        issue(REQ_RELEASE, 2);
        issue(REQ_RELEASE, 2);
        issue(REQ_LOOKUP, 2);
        // reuses the lowest free slot
        issue(REQ_ALLOC, 341);
        issue(REQ_RELEASE, 1023);
        issue(REQ_LOOKUP, 1023);
        issue(REQ_LOOKUP, 4);
        issue(REQ_RELEASE, 1);
        issue(REQ_RELEASE, 3);
        issue(REQ_RELEASE, 4);
        issue(REQ_LOOKUP, 1);

        // random phases of fill, churn and noise
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                roll  = $urandom_range(0, 3);
                mix   = (roll == 0) ? MIX_FILL : (roll == 3) ? MIX_NOISE : MIX_CHURN;
                burst = ($urandom_range(0, 3) == 0);
            end
            wait (n_acc == n_pushed);
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL: begin
                    if (roll < 85)
                        issue(REQ_ALLOC, $urandom_range(0, 1023));
                    else
                        issue(REQ_LOOKUP, live_pick());
                end
                MIX_CHURN: begin
                    if ((live_n >= TABLE_SLOTS && roll < 10) ||
                        (live_n < TABLE_SLOTS && live_n < 24 && roll < 80) ||
                        (live_n < TABLE_SLOTS && live_n >= 24 && roll < 50))
                        issue(REQ_ALLOC, $urandom_range(0, 1023));
                    else if ($urandom_range(0, 99) < 85)
                        issue(REQ_RELEASE, live_pick());
                    else
                        issue(REQ_RELEASE, $urandom_range(0, 1023));
                end
                default: begin
                    if (roll < 25)
                        issue(t_req'($urandom_range(0, 3)), 0);
                    else if (roll < 50)
                        issue(t_req'($urandom_range(0, 3)), live_pick());
                    else
                        issue(t_req'($urandom_range(0, 3)), $urandom_range(0, 1023));
                end
            endcase
        end

        wait (n_acc == n_pushed && resp_q.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("%0d requests, %0d responses: ok %0d, full %0d, not found %0d, range %0d",
                 n_acc, n_res, st_cnt[ST_OK], st_cnt[ST_FULL], st_cnt[ST_NOT_FOUND],
                 st_cnt[ST_RANGE]);
        $display("ID counter wrapped %0d times, %0d mismatches", n_wraps, n_err);
        if (n_err == 0 && resp_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
